// File: hw/rtl/ecm_pkg.sv
// ----------------------------------------------------------------------------
// ecm_pkg
// Shared types and codes for the entity id pool and component mask table.
// ----------------------------------------------------------------------------
package ecm_pkg;

  typedef enum logic [2:0] {
    ACT_ALLOC = 3'd0,
    ACT_FREE  = 3'd1,
    ACT_ADD   = 3'd2,
    ACT_HAS   = 3'd3,
    ACT_MATCH = 3'd4,
    ACT_READ  = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [9:0]  entity_id;
    logic [5:0]  component_id;
    logic [63:0] mandatory_mask;
    logic [63:0] one_of_mask;
    logic        use_one_of;
    logic [63:0] exclusion_mask;
  } in_item_t;

  typedef struct packed {
    logic [9:0]  new_entity;
    logic        hit;
    logic [63:0] component_bits;
    status_t     status;
  } out_item_t;

  // free id stack control
  typedef struct packed {
    logic pop;
    logic push;
  } stk_req_t;

  typedef struct packed {
    logic empty;
    logic full;
  } stk_status_t;

endpackage

// File: hw/rtl/entity_id_pool_and_component_mask_table_top.sv
// ----------------------------------------------------------------------------
// entity_id_pool_and_component_mask_table_top
// Entity id pool with a per-entity component bit set table.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req) takes one action item per cycle:
//   allocate, free, add component, has component, match filter, read bits.
//   rsp channel (rsp_valid/rsp_ready/rsp) returns exactly one item per
//   request, in order.
//   Pipeline: the response is registered through the stack RAM read at the
//   accepting edge, then the row RAM read, then the result register.
//   Throughput: one item per cycle when not stalled. A write to a row read by
//   the next item is forwarded around the row RAM.
//   Reset: the free stack holds every id with 0 on top. The row RAM is
//   cleared by a sweep over all ENTITY_SLOTS rows after reset, during which
//   req_ready stays low.
//   Stall: when rsp_ready is low with a response waiting, the whole pipeline
//   holds and req_ready drops until the response is taken.
// ----------------------------------------------------------------------------
module entity_id_pool_and_component_mask_table_top
  import ecm_pkg::*;
#(
  parameter int ENTITY_SLOTS    = 1024,
  parameter int COMPONENT_TYPES = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  in_item_t  req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output out_item_t rsp
);

  localparam int AW = $clog2(ENTITY_SLOTS);
  localparam int CT = COMPONENT_TYPES;
  localparam logic [AW-1:0] LAST_ID = AW'(ENTITY_SLOTS - 1);
  localparam logic [CT-1:0] ONE_BIT = CT'(1);

  // ---------------- stage 0: accept, stack access ----------------
  logic        adv;
  logic        acc;
  logic        in_range;
  logic        alloc_ok;
  logic        free_ok;
  status_t     status0;
  stk_req_t    stk_req;
  stk_status_t stk_stat;
  logic [AW-1:0] pop_id;

  logic          clearing;
  logic [AW-1:0] clr_addr;

  assign adv = !rsp_valid || rsp_ready;
  assign req_ready = adv && !clearing;
  assign acc = req_valid && req_ready;

  assign in_range = 32'(req.entity_id) < 32'(ENTITY_SLOTS);
  assign alloc_ok = (req.action == ACT_ALLOC) && !stk_stat.empty;
  assign free_ok = (req.action == ACT_FREE) && in_range && !stk_stat.full;

  always_comb begin
    status0 = ST_OK;
    if (req.action == ACT_ALLOC) begin
      if (stk_stat.empty) status0 = ST_EMPTY;
    end else if (req.action == ACT_FREE || req.action == ACT_ADD ||
                 req.action == ACT_HAS || req.action == ACT_MATCH ||
                 req.action == ACT_READ) begin
      if (!in_range) begin
        status0 = ST_RANGE;
      end else if (req.action == ACT_FREE && stk_stat.full) begin
        status0 = ST_FULL;
      end
    end
  end

  assign stk_req.pop = acc && alloc_ok;
  assign stk_req.push = acc && free_ok;

  ecm_id_stack #(
    .ENTITY_SLOTS (ENTITY_SLOTS)
  ) u_id_stack (
    .clk     (clk),
    .rst     (rst),
    .req     (stk_req),
    .push_id (AW'(req.entity_id)),
    .stat    (stk_stat),
    .pop_id  (pop_id)
  );

  // ---------------- stage 1: row read ----------------
  logic     s1_valid;
  in_item_t s1_item;
  status_t  s1_status;
  logic     s1_alloc_ok;
  logic     s1_free_ok;
  logic [AW-1:0] s1_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_item <= req;
      s1_status <= status0;
      s1_alloc_ok <= alloc_ok;
      s1_free_ok <= free_ok;
    end
  end

  assign s1_addr = s1_alloc_ok ? pop_id : AW'(s1_item.entity_id);

  // ---------------- stage 2: modify, write back ----------------
  logic     s2_valid;
  in_item_t s2_item;
  status_t  s2_status;
  logic     s2_alloc_ok;
  logic     s2_free_ok;
  logic [AW-1:0] s2_addr;
  logic          fwd;
  logic [CT-1:0] fwd_data;
  logic [CT-1:0] row_rdata;
  logic [CT-1:0] row_ct;
  logic [63:0]   row64;
  logic [CT-1:0] add_row;
  logic          cid_ok;
  logic          s2_we;
  logic [CT-1:0] s2_wdata;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [CT-1:0] ram_wdata;
  out_item_t     rsp_next;

  assign row_ct = fwd ? fwd_data : row_rdata;
  assign row64 = 64'(row_ct);
  assign cid_ok = 32'(s2_item.component_id) < 32'(CT);
  assign add_row = row_ct | (ONE_BIT << s2_item.component_id);

  assign s2_we = s2_valid && adv &&
                 (s2_free_ok ||
                  (s2_item.action == ACT_ADD && s2_status == ST_OK && cid_ok));
  assign s2_wdata = s2_free_ok ? '0 : add_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  // the row being written this edge is not yet visible to the RAM read
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_item <= s1_item;
      s2_status <= s1_status;
      s2_alloc_ok <= s1_alloc_ok;
      s2_free_ok <= s1_free_ok;
      s2_addr <= s1_addr;
      fwd <= s2_we && (s2_addr == s1_addr);
      fwd_data <= s2_wdata;
    end
  end

  // row clearing sweep after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == LAST_ID) begin
        clearing <= 1'b0;
      end
    end
  end

  assign ram_we = clearing || s2_we;
  assign ram_waddr = clearing ? clr_addr : s2_addr;
  assign ram_wdata = clearing ? '0 : s2_wdata;

  ecm_ram #(
    .WIDTH (CT),
    .DEPTH (ENTITY_SLOTS)
  ) u_row_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (adv && s1_valid),
    .raddr (s1_addr),
    .rdata (row_rdata)
  );

  always_comb begin
    rsp_next.new_entity = '0;
    rsp_next.hit = 1'b0;
    rsp_next.component_bits = '0;
    rsp_next.status = s2_status;
    if (s2_status != ST_RANGE && s2_status != ST_EMPTY) begin
      case (s2_item.action)
        ACT_ALLOC: begin
          if (s2_alloc_ok) begin
            rsp_next.new_entity = 10'(s2_addr);
            rsp_next.component_bits = row64;
          end
        end
        ACT_FREE: begin
          if (!s2_free_ok) rsp_next.component_bits = row64;
        end
        ACT_ADD: begin
          rsp_next.component_bits = cid_ok ? 64'(add_row) : row64;
        end
        ACT_HAS: begin
          rsp_next.hit = cid_ok && row64[s2_item.component_id];
          rsp_next.component_bits = row64;
        end
        ACT_MATCH: begin
          rsp_next.hit = ((s2_item.mandatory_mask & row64) == s2_item.mandatory_mask) &&
                         (!s2_item.use_one_of || |(s2_item.one_of_mask & row64)) &&
                         !(|(s2_item.exclusion_mask & row64));
          rsp_next.component_bits = row64;
        end
        ACT_READ: begin
          rsp_next.component_bits = row64;
        end
        default: begin
          rsp_next.status = ST_OK;
        end
      endcase
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (adv) begin
      rsp_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid) begin
      rsp <= rsp_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !req_ready)
    else $error("item accepted during row clear");

  a_no_items_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s1_valid && !s2_valid && !rsp_valid)
    else $error("item in flight during row clear");

  a_no_write_on_error: assert property (@(posedge clk) disable iff (rst)
    s2_we |-> (s2_status == ST_OK))
    else $error("row write for an item with error status");

  a_fwd_on_write: assert property (@(posedge clk) disable iff (rst)
    (adv && s1_valid && s2_we && (s2_addr == s1_addr)) |=> fwd)
    else $error("row forward missed");
`endif

endmodule

// File: hw/rtl/ecm_ram.sv
// ----------------------------------------------------------------------------
// ecm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ecm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read of an address written in the same cycle returns the old data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/ecm_id_stack.sv
// ----------------------------------------------------------------------------
// ecm_id_stack
// Free entity id stack held in a RAM. Entries below the low-water mark were
// never written since reset and read as their reset id.
// ----------------------------------------------------------------------------
module ecm_id_stack
  import ecm_pkg::*;
#(
  parameter int ENTITY_SLOTS = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  stk_req_t                        req,
  input  logic [$clog2(ENTITY_SLOTS)-1:0] push_id,
  output stk_status_t                     stat,
  output logic [$clog2(ENTITY_SLOTS)-1:0] pop_id
);

  localparam int AW = $clog2(ENTITY_SLOTS);
  localparam int CW = $clog2(ENTITY_SLOTS + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(ENTITY_SLOTS);
  localparam logic [AW-1:0] LAST_ID = AW'(ENTITY_SLOTS - 1);

  logic [CW-1:0] count;
  logic [CW-1:0] low;
  logic [CW-1:0] top;
  logic          use_const;
  logic [AW-1:0] const_id;
  logic [AW-1:0] rdata;

  assign top = count - CW'(1);
  assign stat.empty = (count == '0);
  assign stat.full = (count == FULL_COUNT);
  assign pop_id = use_const ? const_id : rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= FULL_COUNT;
      low <= FULL_COUNT;
      use_const <= 1'b0;
    end else if (req.pop) begin
      count <= top;
      use_const <= (top < low);
      if (top < low) begin
        low <= top;
      end
    end else if (req.push) begin
      count <= count + CW'(1);
    end
  end

  // reset content: entry k holds ENTITY_SLOTS-1-k
  always_ff @(posedge clk) begin
    if (req.pop) begin
      const_id <= LAST_ID - AW'(top);
    end
  end

  ecm_ram #(
    .WIDTH (AW),
    .DEPTH (ENTITY_SLOTS)
  ) u_stack_ram (
    .clk   (clk),
    .we    (req.push),
    .waddr (AW'(count)),
    .wdata (push_id),
    .re    (req.pop),
    .raddr (AW'(top)),
    .rdata (rdata)
  );

`ifndef NO_ASSERTIONS
  a_pop_push_excl: assert property (@(posedge clk) disable iff (rst)
    !(req.pop && req.push))
    else $error("stack pop and push in one cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (count <= FULL_COUNT) && (low <= count))
    else $error("stack count or low-water mark out of bounds");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    req.pop |-> !stat.empty)
    else $error("pop from empty stack");
`endif

endmodule

// File: dv/entity_id_pool_and_component_mask_table_top_test.sv
// ----------------------------------------------------------------------------
// entity_id_pool_and_component_mask_table_top_test
// Self-checking bench for the entity id pool / component mask table. Every
// accepted action is replayed on a local copy of the free id stack and the
// row table, and each response is compared with the predicted one in order.
// Stimulus is a directed opener followed by random entity lifecycles, a pool
// drain down to empty, and a mixed tail, with random idles on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module entity_id_pool_and_component_mask_table_top_test;
  import ecm_pkg::*;

  localparam int SLOTS = 1024;
  localparam int TYPES = 64;
  localparam int HOT   = 8;

  // action codes the block treats as no-ops
  localparam logic [2:0] ACT_SPARE6 = 3'd6;
  localparam logic [2:0] ACT_SPARE7 = 3'd7;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  in_item_t  req = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  out_item_t rsp;

  entity_id_pool_and_component_mask_table_top #(
    .ENTITY_SLOTS   (SLOTS),
    .COMPONENT_TYPES(TYPES)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // predictor state
  logic [9:0]  free_stack [SLOTS];
  int          free_cnt;
  logic [63:0] comp_rows [SLOTS];

  in_item_t  pending_actions [$];
  out_item_t predicted_rsp [$];

  int total_items = 0;
  int accepted = 0;
  int fail_count = 0;
  logic req_taken = 1'b0;

  // stimulus-side bookkeeping, only used to shape the sequences
  int          gen_free = SLOTS;
  int          gen_empties = 0;
  logic [9:0]  hot_ids [HOT];
  logic [63:0] hot_bits [HOT];

  int n_alloc = 0, n_empty = 0, n_full = 0, n_match = 0, n_match_hit = 0, n_has_hit = 0;

  int req_calm = 0, rsp_calm = 0;
  int req_gap = 0, rsp_stall = 0;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic out_item_t apply_action(in_item_t it);
    out_item_t   r;
    logic [63:0] row;
    logic [9:0]  id;
    r = '0;
    if (it.action == ACT_ALLOC) begin
      if (free_cnt == 0) begin
        r.status = ST_EMPTY;
      end else begin
        free_cnt--;
        id = free_stack[free_cnt];
        r.new_entity = id;
        r.component_bits = comp_rows[id];
      end
    end else if (it.action > ACT_READ) begin
      r = '0;
    end else if (int'(it.entity_id) >= SLOTS) begin
      r.status = ST_RANGE;
    end else begin
      row = comp_rows[it.entity_id];
      case (it.action)
        ACT_FREE: begin
          if (free_cnt >= SLOTS) begin
            r.status = ST_FULL;
            r.component_bits = row;
          end else begin
            free_stack[free_cnt] = it.entity_id;
            free_cnt++;
            comp_rows[it.entity_id] = '0;
          end
        end
        ACT_ADD: begin
          if (int'(it.component_id) < TYPES) begin
            row[it.component_id] = 1'b1;
            comp_rows[it.entity_id] = row;
          end
          r.component_bits = row;
        end
        ACT_HAS: begin
          r.hit = (int'(it.component_id) < TYPES) && row[it.component_id];
          r.component_bits = row;
        end
        ACT_MATCH: begin
          r.hit = ((it.mandatory_mask & row) == it.mandatory_mask) &&
                  (!it.use_one_of || (it.one_of_mask & row) != '0) &&
                  ((it.exclusion_mask & row) == '0);
          r.component_bits = row;
        end
        default: r.component_bits = row;
      endcase
    end
    return r;
  endfunction

  // mostly back-to-back, sometimes short gaps, rarely long ones,
  // with occasional stretches of no idling at all
  task automatic idle_len(inout int calm, output int n);
    int r;
    if (calm > 0) begin
      calm--;
      n = 0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 2) begin
        calm = $urandom_range(20, 120);
        n = 0;
      end else if (r < 68) begin
        n = 0;
      end else if (r < 93) begin
        n = $urandom_range(1, 3);
      end else begin
        n = $urandom_range(4, 30);
      end
    end
  endtask

  task automatic queue_item(input in_item_t it);
    logic freed;
    int   k;
    freed = (it.action == ACT_FREE) && (gen_free < SLOTS);
    if (it.action == ACT_ALLOC) begin
      if (gen_free > 0) gen_free--;
      else gen_empties++;
    end
    if (freed) gen_free++;
    for (k = 0; k < HOT; k++) begin
      if (hot_ids[k] == it.entity_id) begin
        if (freed) hot_bits[k] = '0;
        if (it.action == ACT_ADD) hot_bits[k][it.component_id] = 1'b1;
      end
    end
    pending_actions = {pending_actions, it};
    total_items++;
  endtask

  task automatic directed(input logic [2:0] act, input logic [9:0] eid, input logic [5:0] cid,
                          input logic [63:0] mand, input logic [63:0] oneof,
                          input logic use1, input logic [63:0] excl);
    in_item_t it;
    it.action = act;
    it.entity_id = eid;
    it.component_id = cid;
    it.mandatory_mask = mand;
    it.one_of_mask = oneof;
    it.use_one_of = use1;
    it.exclusion_mask = excl;
    queue_item(it);
  endtask

  task automatic gen_mixed(input int alloc_w, input int free_w);
    in_item_t    it;
    int          r, k;
    logic [63:0] have;
    it.action = ACT_READ;
    it.entity_id = 10'($urandom_range(0, SLOTS - 1));
    it.component_id = 6'($urandom_range(0, TYPES - 1));
    it.mandatory_mask = rand64();
    it.one_of_mask = rand64();
    it.use_one_of = 1'($urandom_range(0, 1));
    it.exclusion_mask = rand64();
    k = $urandom_range(0, HOT - 1);
    have = '0;
    if ($urandom_range(0, 4) != 0) begin
      it.entity_id = hot_ids[k];
      have = hot_bits[k];
    end
    // narrow component pool so has/match see populated rows
    if ($urandom_range(0, 1) == 1)
      it.component_id = 6'($urandom_range(0, 1) ? $urandom_range(0, 5) :
                                                  $urandom_range(58, 63));
    r = $urandom_range(0, 99);
    if (r < alloc_w) begin
      it.action = ACT_ALLOC;
    end else if (r < alloc_w + free_w) begin
      it.action = ACT_FREE;
    end else begin
      r = $urandom_range(0, 49);
      if (r < 12) it.action = ACT_ADD;
      else if (r < 22) it.action = ACT_HAS;
      else if (r < 44) it.action = ACT_MATCH;
      else if (r < 48) it.action = ACT_READ;
      else it.action = (r == 48) ? ACT_SPARE6 : ACT_SPARE7;
    end
    if (it.action == ACT_MATCH) begin
      case ($urandom_range(0, 3))
        0: it.mandatory_mask = '0;
        1: it.mandatory_mask = have & rand64();
        2: it.mandatory_mask = have;
        default: ;
      endcase
      case ($urandom_range(0, 3))
        0: it.one_of_mask = have & rand64();
        1: it.one_of_mask = have;
        2: it.one_of_mask = '0;
        default: ;
      endcase
      case ($urandom_range(0, 3))
        0: it.exclusion_mask = '0;
        1: it.exclusion_mask = ~have & rand64();
        2: it.exclusion_mask = ~have;
        default: ;
      endcase
    end
    queue_item(it);
  endtask

  // request driver
  always @(negedge clk) begin : drive_req
    int n;
    if (!rst) begin
      if (!req_valid || req_taken) begin
        if (req_gap > 0) begin
          req_gap--;
          req_valid <= 1'b0;
        end else if (pending_actions.size() != 0) begin
          req <= pending_actions.pop_front();
          req_valid <= 1'b1;
          idle_len(req_calm, n);
          req_gap = n;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // response back-pressure
  always @(negedge clk) begin : drive_rsp_ready
    int n;
    if (!rst) begin
      if (rsp_stall > 0) begin
        rsp_stall--;
        rsp_ready <= 1'b0;
      end else begin
        idle_len(rsp_calm, n);
        rsp_ready <= (n == 0);
        rsp_stall = (n > 0) ? n - 1 : 0;
      end
    end
  end

  // monitor: check responses, then predict newly accepted actions
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= req_valid && req_ready;
      if (rsp_valid && rsp_ready) begin
        if (predicted_rsp.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected response: ent=%0d hit=%0b bits=%h st=%0d",
                     rsp.new_entity, rsp.hit, rsp.component_bits, rsp.status);
        end else begin
          want = predicted_rsp.pop_front();
          if (rsp.new_entity !== want.new_entity || rsp.hit !== want.hit ||
              rsp.component_bits !== want.component_bits || rsp.status !== want.status) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("mismatch: want ent=%0d hit=%0b bits=%h st=%0d",
                       want.new_entity, want.hit, want.component_bits, want.status);
              $display("          got  ent=%0d hit=%0b bits=%h st=%0d",
                       rsp.new_entity, rsp.hit, rsp.component_bits, rsp.status);
            end
          end
        end
      end
      if (req_valid && req_ready) begin
        want = apply_action(req);
        predicted_rsp = {predicted_rsp, want};
        accepted++;
        if (req.action == ACT_ALLOC) n_alloc++;
        if (want.status == ST_EMPTY) n_empty++;
        if (want.status == ST_FULL) n_full++;
        if (req.action == ACT_MATCH) begin
          n_match++;
          if (want.hit) n_match_hit++;
        end
        if (req.action == ACT_HAS && want.hit) n_has_hit++;
      end
    end
  end

  initial begin : run
    int i, guard;
    for (i = 0; i < SLOTS; i++) begin
      free_stack[i] = 10'(SLOTS - 1 - i);
      comp_rows[i] = '0;
    end
    free_cnt = SLOTS;
    hot_ids[0] = '0;
    hot_ids[1] = 10'(SLOTS - 1);
    for (i = 2; i < HOT; i++) hot_ids[i] = 10'($urandom_range(0, SLOTS - 1));
    for (i = 0; i < HOT; i++) hot_bits[i] = '0;

    // free on a full pool, then allocate and exercise rows 0 and 1
    directed(ACT_FREE,  10'd5,    6'd0,  '0, '0, 1'b0, '0);
    directed(ACT_READ,  10'd1023, 6'd63, '1, '1, 1'b1, '1);
    directed(ACT_ALLOC, 10'd1023, 6'd63, '1, '1, 1'b1, '1);
    directed(ACT_ALLOC, 10'd0,    6'd0,  '0, '0, 1'b0, '0);
    directed(ACT_ADD,   10'd0,    6'd0,  '0, '0, 1'b0, '0);
    directed(ACT_ADD,   10'd0,    6'd63, '0, '0, 1'b0, '0);
    directed(ACT_ADD,   10'd0,    6'd63, '0, '0, 1'b0, '0);
    directed(ACT_HAS,   10'd0,    6'd63, '0, '0, 1'b0, '0);
    directed(ACT_HAS,   10'd0,    6'd1,  '0, '0, 1'b0, '0);
    directed(ACT_MATCH, 10'd0, 6'd0, 64'h8000_0000_0000_0001, 64'h8000_0000_0000_0000,
             1'b1, '0);
    directed(ACT_MATCH, 10'd0, 6'd0, '1, '0, 1'b0, '0);
    directed(ACT_MATCH, 10'd0, 6'd0, '0, '0, 1'b1, '0);
    directed(ACT_MATCH, 10'd0, 6'd0, '0, '1, 1'b0, '0);
    directed(ACT_MATCH, 10'd0, 6'd0, '0, '1, 1'b1, '1);
    directed(ACT_MATCH, 10'd1, 6'd0, '0, '0, 1'b0, '0);
    // add to a row that is still in the pool; allocate returns it later
    directed(ACT_ADD,    10'd2,    6'd5,  '0, '0, 1'b0, '0);
    directed(ACT_SPARE6, 10'd1023, 6'd63, '1, '1, 1'b1, '1);
    directed(ACT_SPARE7, 10'd1023, 6'd63, '1, '1, 1'b1, '1);
    // double free of the same id, then both copies come back out
    directed(ACT_FREE,  10'd0, 6'd0,  '0, '0, 1'b0, '0);
    directed(ACT_FREE,  10'd0, 6'd0,  '0, '0, 1'b0, '0);
    directed(ACT_ADD,   10'd1, 6'd40, '0, '0, 1'b0, '0);
    directed(ACT_FREE,  10'd1, 6'd0,  '0, '0, 1'b0, '0);
    directed(ACT_ALLOC, 10'd0, 6'd0,  '0, '0, 1'b0, '0);
    directed(ACT_ALLOC, 10'd0, 6'd0,  '0, '0, 1'b0, '0);
    directed(ACT_ALLOC, 10'd0, 6'd0,  '0, '0, 1'b0, '0);

    for (i = 0; i < 300; i++) gen_mixed(15, 10);
    // drain the pool and bounce off empty a few times
    guard = 0;
    while (gen_empties < 12 && guard < 3000) begin
      gen_mixed(88, 2);
      guard++;
    end
    for (i = 0; i < 250; i++) gen_mixed(20, 30);

    repeat (3) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (accepted < total_items) @(posedge clk);
    while (predicted_rsp.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d actions: %0d allocate (%0d on empty pool), %0d free on full pool",
             accepted, n_alloc, n_empty, n_full);
    $display("match filter %0d (%0d hit), has component hits %0d, %0d errors",
             n_match, n_match_hit, n_has_hit, fail_count);
    if (fail_count == 0 && predicted_rsp.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("timeout: %0d of %0d items accepted, %0d responses outstanding",
             accepted, total_items, predicted_rsp.size());
    $display("FAIL");
    $finish;
  end

endmodule
